@@ hw/rtl/convex_hull_edge_walk_defines.svh @@
// Assertion macros for the convex hull edge walk.
// No dependencies; included by the RTL files that carry assertions.
`ifndef CONVEX_HULL_EDGE_WALK_DEFINES_SVH
`define CONVEX_HULL_EDGE_WALK_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CHEW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CHEW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hw/rtl/chew_pkg.sv @@
// Shared types and constants for the convex hull edge walk.
// No dependencies.
package chew_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_W        = 16;
   localparam int PORT_IDX_W     = 6;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [PORT_IDX_W-1:0]     port_idx_type;
   typedef logic [1:0]                status_type;

   localparam status_type STATUS_EDGE  = 2'd0; // valid hull edge
   localparam status_type STATUS_FEW   = 2'd1; // fewer than two points
   localparam status_type STATUS_STUCK = 2'd2; // no candidate or step limit

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN_RD,
      ST_SCAN,
      ST_CAND,
      ST_CAND_RD,
      ST_MUL_A,
      ST_MUL_B,
      ST_CMP,
      ST_EMIT
   } state_type;

endpackage

@@ hw/rtl/convex_hull_edge_walk.sv @@
// Convex hull edge walk: points load one word per cycle into an internal
// memory while req_ready is high; the word flagged last_point closes the set
// and starts a gift-wrap walk (a set of fewer than two points instead gets a
// single STATUS_FEW word). The walk scans for the start (largest x, highest
// index), skips the current and previous vertex as candidates, fetches each
// tested candidate and tests it against the stored points in turn (one shared
// 17x17 multiplier forms the two products of that point's cross product, then
// a compare), and emits each edge, waiting while rsp_ready holds back the
// previous edge word. req_ready stays low for the whole walk.
// Depends on chew_pkg and convex_hull_edge_walk_defines.svh.
`include "convex_hull_edge_walk_defines.svh"

module convex_hull_edge_walk
   import chew_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // point words
   input  logic         req_valid,
   output logic         req_ready,
   input  coord_type    req_point_x,
   input  coord_type    req_point_y,
   input  logic         req_last_point,
   // edge words
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output port_idx_type rsp_from_index,
   output port_idx_type rsp_to_index,
   output status_type   rsp_status,
   output logic         rsp_last_edge
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int DIF_W = COORD_W + 1;
   localparam int PRD_W = 2 * DIF_W;

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic signed [DIF_W-1:0] dif_type;
   typedef logic signed [PRD_W-1:0] prd_type;

   // point memory: y in the upper half, x in the lower half
   logic [2*COORD_W-1:0] mem [MAX_POINTS];
   logic [2*COORD_W-1:0] rd_data_ff;
   idx_type              rd_addr;
   logic                 mem_we;

   state_type  state_ff, state_in;
   cnt_type    count_ff, count_in;     // points stored in this run
   idx_type    start_ff, start_in;
   idx_type    cur_ff, cur_in;
   idx_type    prev_ff, prev_in;
   logic       prev_valid_ff, prev_valid_in;
   cnt_type    edges_ff, edges_in;
   cnt_type    cand_ff, cand_in;       // candidate under test, may reach n
   cnt_type    j_ff, j_in;             // point tested against the candidate
   coord_type  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type  cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   dif_type    dx_ff, dx_in, dy_ff, dy_in, ex_ff, ex_in;
   prd_type    prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic       pos_ff, pos_in, neg_ff, neg_in;
   idx_type    pend_from_ff, pend_from_in, pend_to_ff, pend_to_in;
   status_type pend_status_ff, pend_status_in;
   logic       pend_last_ff, pend_last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   idx_type    rsp_from_ff, rsp_from_in, rsp_to_ff, rsp_to_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;

   coord_type rd_x, rd_y;
   dif_type   mul_op1, mul_op2;
   prd_type   mul_out;
   cnt_type   n_new;
   logic      rsp_free;
   logic      scan_take;
   logic      pos_n, neg_n;

   assign rd_x     = rd_data_ff[COORD_W-1:0];
   assign rd_y     = rd_data_ff[2*COORD_W-1:COORD_W];
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_LOAD);

   // count after this word, with the store saturating at MAX_POINTS
   assign n_new = (count_ff < CNT_W'(MAX_POINTS)) ? count_ff + CNT_W'(1) : count_ff;

   // shared multiplier: dx*(yj-yc) first, then dy*(xj-xc)
   assign mul_op1 = (state_ff == ST_MUL_A) ? dx_ff : dy_ff;
   assign mul_op2 = (state_ff == ST_MUL_A)
                  ? ({rd_y[COORD_W-1], rd_y} - {cur_y_ff[COORD_W-1], cur_y_ff})
                  : ex_ff;
   assign mul_out = mul_op1 * mul_op2;

   assign scan_take = (j_ff == '0) || (rd_x >= cur_x_ff);
   assign pos_n     = pos_ff || (prod_a_ff > prod_b_ff);
   assign neg_n     = neg_ff || (prod_a_ff < prod_b_ff);

   assign mem_we  = req_valid && req_ready && (count_ff < CNT_W'(MAX_POINTS));
   assign rd_addr = (state_ff == ST_CAND) ? cand_ff[IDX_W-1:0] : j_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= {req_point_y, req_point_x};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         prev_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         prev_valid_ff <= prev_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff       <= start_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      edges_ff       <= edges_in;
      cand_ff        <= cand_in;
      j_ff           <= j_in;
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      cand_x_ff      <= cand_x_in;
      cand_y_ff      <= cand_y_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      ex_ff          <= ex_in;
      prod_a_ff      <= prod_a_in;
      prod_b_ff      <= prod_b_in;
      pos_ff         <= pos_in;
      neg_ff         <= neg_in;
      pend_from_ff   <= pend_from_in;
      pend_to_ff     <= pend_to_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      rsp_from_ff    <= rsp_from_in;
      rsp_to_ff      <= rsp_to_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      start_in       = start_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      prev_valid_in  = prev_valid_ff;
      edges_in       = edges_ff;
      cand_in        = cand_ff;
      j_in           = j_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      cand_x_in      = cand_x_ff;
      cand_y_in      = cand_y_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      ex_in          = ex_ff;
      prod_a_in      = prod_a_ff;
      prod_b_in      = prod_b_ff;
      pos_in         = pos_ff;
      neg_in         = neg_ff;
      pend_from_in   = pend_from_ff;
      pend_to_in     = pend_to_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_from_in    = rsp_from_ff;
      rsp_to_in      = rsp_to_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               count_in = n_new;
               if (req_last_point) begin
                  j_in = '0;
                  if (n_new < CNT_W'(2)) begin
                     pend_from_in   = '0;
                     pend_to_in     = '0;
                     pend_status_in = STATUS_FEW;
                     pend_last_in   = 1'b1;
                     state_in       = ST_EMIT;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end

         ST_SCAN_RD: begin
            // read of point 0 in flight
            j_in     = '0;
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            // ties go to the later index
            if (scan_take) begin
               cur_in   = j_ff[IDX_W-1:0];
               cur_x_in = rd_x;
               cur_y_in = rd_y;
            end
            if (j_ff == count_ff - CNT_W'(1)) begin
               start_in      = scan_take ? j_ff[IDX_W-1:0] : cur_ff;
               prev_valid_in = 1'b0;
               prev_in       = '0;
               edges_in      = '0;
               cand_in       = '0;
               state_in      = ST_CAND;
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end

         ST_CAND: begin
            if (cand_ff == count_ff) begin
               pend_from_in   = cur_ff;
               pend_to_in     = cur_ff;
               pend_status_in = STATUS_STUCK;
               pend_last_in   = 1'b1;
               state_in       = ST_EMIT;
            end else if ((cand_ff == CNT_W'(cur_ff)) ||
                         (prev_valid_ff && (cand_ff == CNT_W'(prev_ff)))) begin
               cand_in = cand_ff + CNT_W'(1);
            end else begin
               state_in = ST_CAND_RD;
            end
         end

         ST_CAND_RD: begin
            // candidate word arrives; start the sweep at point 0
            cand_x_in = rd_x;
            cand_y_in = rd_y;
            dx_in     = {rd_x[COORD_W-1], rd_x} - {cur_x_ff[COORD_W-1], cur_x_ff};
            dy_in     = {rd_y[COORD_W-1], rd_y} - {cur_y_ff[COORD_W-1], cur_y_ff};
            pos_in    = 1'b0;
            neg_in    = 1'b0;
            j_in      = '0;
            state_in  = ST_MUL_A;
         end

         ST_MUL_A: begin
            prod_a_in = mul_out;
            ex_in     = {rd_x[COORD_W-1], rd_x} - {cur_x_ff[COORD_W-1], cur_x_ff};
            state_in  = ST_MUL_B;
         end

         ST_MUL_B: begin
            prod_b_in = mul_out;
            state_in  = ST_CMP;
         end

         ST_CMP: begin
            // cross product sign is sign(prod_a - prod_b)
            pos_in = pos_n;
            neg_in = neg_n;
            if (pos_n && neg_n) begin
               cand_in  = cand_ff + CNT_W'(1);
               state_in = ST_CAND;
            end else if (j_ff == count_ff - CNT_W'(1)) begin
               // supporting line found: step along the hull
               prev_in        = cur_ff;
               prev_valid_in  = 1'b1;
               cur_in         = cand_ff[IDX_W-1:0];
               cur_x_in       = cand_x_ff;
               cur_y_in       = cand_y_ff;
               edges_in       = edges_ff + CNT_W'(1);
               pend_from_in   = cur_ff;
               pend_to_in     = cand_ff[IDX_W-1:0];
               if (cand_ff == CNT_W'(start_ff)) begin
                  pend_status_in = STATUS_EDGE;
                  pend_last_in   = 1'b1;
               end else if (edges_ff + CNT_W'(1) >= count_ff) begin
                  pend_status_in = STATUS_STUCK;
                  pend_last_in   = 1'b1;
               end else begin
                  pend_status_in = STATUS_EDGE;
                  pend_last_in   = 1'b0;
               end
               state_in = ST_EMIT;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_MUL_A;
            end
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_from_in   = pend_from_ff;
               rsp_to_in     = pend_to_ff;
               rsp_status_in = pend_status_ff;
               rsp_last_in   = pend_last_ff;
               if (pend_last_ff) begin
                  count_in      = '0;
                  prev_valid_in = 1'b0;
                  state_in      = ST_LOAD;
               end else begin
                  cand_in  = '0;
                  state_in = ST_CAND;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_from_index = port_idx_type'(rsp_from_ff);
   assign rsp_to_index   = port_idx_type'(rsp_to_ff);
   assign rsp_status     = rsp_status_ff;
   assign rsp_last_edge  = rsp_last_ff;

   // the two products of one point are formed back to back
   `CHEW_ASSERT_NEXT(a_mul_order, clock, reset, state_ff == ST_MUL_A, state_ff == ST_MUL_B)
   // a short point set reports once, as the run's final word, at index zero
   `CHEW_ASSERT_SAME(a_few_final, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_FEW),
      rsp_last_ff && (rsp_from_ff == '0) && (rsp_to_ff == '0))
   // a tested candidate is never the current or previous vertex
   `CHEW_ASSERT_SAME(a_cand_fresh, clock, reset,
      (state_ff == ST_CMP) && prev_valid_ff,
      (cand_ff != CNT_W'(prev_ff)) && (cand_ff != CNT_W'(cur_ff)))
   // the final word of a run empties the store and reopens the input
   `CHEW_ASSERT_NEXT(a_run_clears, clock, reset,
      (state_ff == ST_EMIT) && rsp_free && pend_last_ff,
      (state_ff == ST_LOAD) && (count_ff == '0))

endmodule

@@ dv/tb_convex_hull_edge_walk.sv @@
// Self-checking testbench for convex_hull_edge_walk: point words in, hull edge words out,
// checked against an in-bench gift-wrap predictor under varied idle and stall patterns.
// Depends on chew_pkg and the convex_hull_edge_walk RTL.
module tb_convex_hull_edge_walk;
   import chew_pkg::*;

   localparam int STORE_DEPTH = 64;

   typedef struct {
      port_idx_type src_idx;
      port_idx_type dst_idx;
      status_type   status;
      logic         last_edge;
   } hull_edge_type;

   // how the points of one set are spread out
   typedef enum int {
      SPREAD_FULL,   // whole 16-bit range
      SPREAD_TINY,   // -3..3, lots of duplicates and collinear triples
      SPREAD_GRID,   // -100..100
      SPREAD_LINE    // every point on one line through the origin
   } spread_type;

   // Predicts the edge words of each point set and checks the DUT against them.
   class hull_walk_board;
      coord_type     xs [STORE_DEPTH];
      coord_type     ys [STORE_DEPTH];
      int            count;
      hull_edge_type pending_edges [$];
      int            mismatches;

      function new();
         count      = 0;
         mismatches = 0;
      endfunction

      function void push_edge(int src, int dst, status_type st, logic last);
         hull_edge_type e;
         e.src_idx   = port_idx_type'(src);
         e.dst_idx   = port_idx_type'(dst);
         e.status    = st;
         e.last_edge = last;
         pending_edges.push_back(e);
      endfunction

      // One accepted point word. Words past a full store are dropped, but a
      // dropped word that carries last_point still closes the set.
      function void take_point(coord_type x, coord_type y, logic last);
         int     start, cur, prev, found, edges, i, j;
         bit     prev_ok, have, done, pos, neg;
         longint dx, dy, cr;
         if (count < STORE_DEPTH) begin
            xs[count] = x;
            ys[count] = y;
            count++;
         end
         if (!last) return;
         if (count < 2) begin
            push_edge(0, 0, STATUS_FEW, 1'b1);
         end else begin
            // start at the highest index among the points with the largest x
            start = 0;
            for (i = 1; i < count; i++)
               if (xs[i] >= xs[start]) start = i;
            cur     = start;
            prev    = 0;
            prev_ok = 0;
            edges   = 0;
            done    = 0;
            while (!done) begin
               have  = 0;
               found = 0;
               for (i = 0; i < count && !have; i++) begin
                  if (i == cur || (prev_ok && i == prev)) continue;
                  // candidate is taken when no point lies strictly on both sides
                  dx  = longint'(xs[i]) - longint'(xs[cur]);
                  dy  = longint'(ys[i]) - longint'(ys[cur]);
                  pos = 0;
                  neg = 0;
                  for (j = 0; j < count; j++) begin
                     cr = dx * (longint'(ys[j]) - longint'(ys[cur]))
                        - dy * (longint'(xs[j]) - longint'(xs[cur]));
                     if (cr > 0) pos = 1;
                     else if (cr < 0) neg = 1;
                  end
                  if (!(pos && neg)) begin
                     found = i;
                     have  = 1;
                  end
               end
               if (!have) begin
                  push_edge(cur, cur, STATUS_STUCK, 1'b1);
                  done = 1;
               end else begin
                  prev    = cur;
                  prev_ok = 1;
                  cur     = found;
                  edges++;
                  if (cur == start) begin
                     push_edge(prev, cur, STATUS_EDGE, 1'b1);
                     done = 1;
                  end else if (edges >= count) begin
                     push_edge(prev, cur, STATUS_STUCK, 1'b1);
                     done = 1;
                  end else begin
                     push_edge(prev, cur, STATUS_EDGE, 1'b0);
                  end
               end
            end
         end
         count = 0;
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 100) $display("mismatch: %s", what);
      endtask

      task match_edge(port_idx_type src, port_idx_type dst, status_type st, logic last);
         hull_edge_type e;
         if (pending_edges.size() == 0) begin
            report($sformatf("edge word %0d->%0d st %0d with nothing pending", src, dst, st));
         end else begin
            e = pending_edges.pop_front();
            if (src !== e.src_idx)
               report($sformatf("from_index %0d, want %0d", src, e.src_idx));
            if (dst !== e.dst_idx)
               report($sformatf("to_index %0d, want %0d", dst, e.dst_idx));
            if (st !== e.status)
               report($sformatf("status %0d, want %0d", st, e.status));
            if (last !== e.last_edge)
               report($sformatf("last_edge %0b, want %0b", last, e.last_edge));
         end
      endtask

      function int pending();
         return pending_edges.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   coord_type    req_point_x = '0;
   coord_type    req_point_y = '0;
   logic         req_last_point = 1'b0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   port_idx_type rsp_from_index;
   port_idx_type rsp_to_index;
   status_type   rsp_status;
   logic         rsp_last_edge;

   hull_walk_board board;
   bit             req_fire = 0;   // handshake seen at the last falling edge
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;

   convex_hull_edge_walk u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_from_index (rsp_from_index),
      .rsp_to_index   (rsp_to_index),
      .rsp_status     (rsp_status),
      .rsp_last_edge  (rsp_last_edge)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Monitor. Everything is stable mid-cycle, so a handshake seen at the falling
   // edge is exactly the one taken at the next rising edge. Edge words are
   // checked before a point word is noted: they always belong to an earlier set.
   always @(negedge clock) begin
      req_fire = !reset && req_valid && (req_ready === 1'b1);
      if (!reset && (rsp_valid === 1'b1) && rsp_ready)
         board.match_edge(rsp_from_index, rsp_to_index, rsp_status, rsp_last_edge);
      if (req_fire)
         board.take_point(req_point_x, req_point_y, req_last_point);
   end

   // Present one point word after an optional random gap; return once taken.
   // Valid stays high afterwards so back-to-back words need no toggle.
   task automatic send_word(input coord_type x, input coord_type y, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_point_x    <= x;
      req_point_y    <= y;
      req_last_point <= last;
      do @(posedge clock); while (!req_fire);
   endtask

   // One point set of n words, the last one flagged.
   task automatic send_set(input int n, input spread_type spread);
      int        k, t;
      coord_type x, y, sx, sy;
      sx = coord_type'($urandom_range(0, 6)) - 16'sd3;
      sy = coord_type'($urandom_range(0, 6)) - 16'sd3;
      for (k = 0; k < n; k++) begin
         case (spread)
            SPREAD_FULL: begin
               x = coord_type'($urandom);
               y = coord_type'($urandom);
            end
            SPREAD_TINY: begin
               x = coord_type'($urandom_range(0, 6)) - 16'sd3;
               y = coord_type'($urandom_range(0, 6)) - 16'sd3;
            end
            SPREAD_GRID: begin
               x = coord_type'($urandom_range(0, 200)) - 16'sd100;
               y = coord_type'($urandom_range(0, 200)) - 16'sd100;
            end
            default: begin
               t = $urandom_range(0, 16) - 8;
               x = coord_type'(t) * sx;
               y = coord_type'(t) * sy;
            end
         endcase
         send_word(x, y, k == n - 1);
      end
   endtask

   // Drop valid and hold the sender until every predicted edge has come back.
   task automatic drain_edges();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int sent, n, phase;
      int idle_tbl  [4];
      int stall_tbl [4];
      idle_tbl  = '{0, 51, 0, 30};
      stall_tbl = '{0, 0, 51, 30};
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets
      send_word(16'sd32767, -16'sd32768, 1'b1);          // lone point: too few
      send_word(-16'sd32768, 16'sd32767, 1'b0);          // two points: one edge, then stuck
      send_word(16'sd32767, -16'sd32768, 1'b1);
      send_word(-16'sd32768, -16'sd32768, 1'b0);         // triangle at the corners
      send_word(16'sd32767, -16'sd32768, 1'b0);
      send_word(16'sd0, 16'sd32767, 1'b1);
      send_word(16'sd0, 16'sd0, 1'b0);                   // square, with a point on an
      send_word(16'sd10, 16'sd0, 1'b0);                  // edge, a duplicate corner and
      send_word(16'sd5, 16'sd0, 1'b0);                   // several ties on largest x
      send_word(16'sd10, 16'sd10, 1'b0);
      send_word(16'sd0, 16'sd10, 1'b0);
      send_word(16'sd10, 16'sd10, 1'b0);
      send_word(16'sd10, 16'sd5, 1'b1);
      send_word(16'sd0, 16'sd0, 1'b0);                   // all on one line
      send_word(16'sd2, 16'sd2, 1'b0);
      send_word(16'sd1, 16'sd1, 1'b0);
      send_word(16'sd3, 16'sd3, 1'b1);
      send_word(16'sd7, -16'sd7, 1'b0);                  // every point the same
      send_word(16'sd7, -16'sd7, 1'b0);
      send_word(16'sd7, -16'sd7, 1'b1);
      drain_edges();

      // random sets, one idle/stall pattern per phase
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_tbl[phase];
         rsp_stall_pct = stall_tbl[phase];
         sent = 0;
         // overfill the store once: the last two words are dropped, the
         // flagged one still closes the set
         if (phase == 1) send_set(STORE_DEPTH + 2, SPREAD_FULL);
         while (sent < 26) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
            send_set(n, spread_type'($urandom_range(0, 3)));
            sent += n;
         end
         drain_edges();
      end

      repeat (100) @(posedge clock);
      if (board.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // hang guard, far beyond the slowest legal walk sequence
   initial begin
      #50000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/chew_pkg.sv
hw/rtl/convex_hull_edge_walk.sv
dv/tb_convex_hull_edge_walk.sv
